// ===== sv/genotype_pair_contingency_counter_macros.svh =====
// Assertion helpers for the top module, which checks its own logic.
`ifndef GENOTYPE_PAIR_CONTINGENCY_COUNTER_MACROS_SVH
`define GENOTYPE_PAIR_CONTINGENCY_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define GPCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpcc check failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define GPCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpcc check failed");

`endif

// ===== sv/gpcc_pkg.sv =====
`default_nettype none

package gpcc_pkg;

  localparam int GENO_W          = 32;
  localparam int TALLY_W         = 16;
  localparam int CELL_W          = 4;
  localparam int CELL_COUNT      = 9;
  localparam int GENO_COUNT      = 3;
  localparam int POP_W           = $clog2(GENO_W + 1);
  localparam int WORD_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CELL_W-1:0]  LAST_CELL    = CELL_W'(CELL_COUNT - 1);
  localparam logic [TALLY_W-1:0] TALLY_MAX    = {TALLY_W{1'b1}};
  localparam logic               KIND_CONTROL = 1'b0;
  localparam logic               KIND_CASE    = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [GENO_W-1:0] a_geno0_bits;
    logic [GENO_W-1:0] a_geno1_bits;
    logic [GENO_W-1:0] a_geno2_bits;
    logic [GENO_W-1:0] b_geno0_bits;
    logic [GENO_W-1:0] b_geno1_bits;
    logic [GENO_W-1:0] b_geno2_bits;
    logic              final_word;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_index;
    logic [TALLY_W-1:0] control_count;
    logic [TALLY_W-1:0] case_count;
    logic               last_cell;
  } out_item_t;

  // One classified item: the nine per-cell bit counts plus its flags.
  typedef struct packed {
    logic                             kind;
    logic                             final_word;
    logic [CELL_COUNT-1:0][POP_W-1:0] pop;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== sv/genotype_pair_contingency_counter.sv =====
// Channel   Ports                          Payload      Moves
// input     in_valid / in_ready / in_data  in_item_t    one genotype word pair
// result    out_valid / out_ready / out_data out_item_t one contingency cell
//
// One input item is accepted every cycle while the queue has room; the nine
// AND-popcounts of an item are formed in the cycle it is accepted.
// A final item yields nine result items through the single output register;
// a later final item waits in the queue until the last of them is loaded there.
// Reset (rst_n low at a clock edge) clears tallies, queue and the output valid flag.
// A stalled result side holds such a final item, the queue fills, in_ready drops.
`default_nettype none

module genotype_pair_contingency_counter
  import gpcc_pkg::*;
#(
  parameter int WORD_BITS   = WORD_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  // The front classifies each item into nine bit counts, the queue decouples
  // it from the back, and the back folds counts into the saturating tallies
  // and plays out the table when a final item arrives.
  q_stat_t  q_stat;
  q_entry_t wr_entry;
  q_entry_t rd_entry;
  logic     push;
  logic     pop;

  gpcc_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .entry    (wr_entry)
  );

  gpcc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .q_stat   (q_stat),
    .rd_entry (rd_entry)
  );

  gpcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .rd_entry  (rd_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`include "genotype_pair_contingency_counter_macros.svh"

  // The front never writes into a full queue.
  `GPCC_ASSERT_IMP(a_no_push_full, push, !q_stat.full)
  // The back never takes an item from an empty queue.
  `GPCC_ASSERT_IMP(a_no_pop_empty, pop, q_stat.valid)
  // Emitted cells stay in the table and only cell eight closes a run.
  `GPCC_ASSERT_IMP(a_cell_range, out_valid, out_data.cell_index <= LAST_CELL)
  `GPCC_ASSERT_IMP(a_last_flag, out_valid,
                   out_data.last_cell == (out_data.cell_index == LAST_CELL))

endmodule

`default_nettype wire

// ===== sv/gpcc_front.sv =====
`default_nettype none

module gpcc_front
  import gpcc_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire q_stat_t  q_stat,
  output logic          push,
  output q_entry_t      entry
);

  localparam int USED_BITS = (WORD_BITS < GENO_W) ? WORD_BITS : GENO_W;
  localparam logic [GENO_W-1:0] USED_MASK = {GENO_W{1'b1}} >> (GENO_W - USED_BITS);

  // Pairwise adder tree: five levels for a 32-bit word.
  function automatic logic [POP_W-1:0] pop_count(input logic [GENO_W-1:0] w);
    logic [POP_W-1:0] acc [GENO_W];
    for (int k = 0; k < GENO_W; k++) acc[k] = POP_W'(w[k]);
    for (int step = 1; step < GENO_W; step = step * 2) begin
      for (int k = 0; k < GENO_W; k = k + 2 * step) begin
        acc[k] = acc[k] + acc[k + step];
      end
    end
    return acc[0];
  endfunction

  logic [GENO_W-1:0] a_m [GENO_COUNT];
  logic [GENO_W-1:0] b_m [GENO_COUNT];

  assign in_ready = ~q_stat.full;
  assign push     = in_valid & ~q_stat.full;

  always_comb begin
    a_m[0] = in_data.a_geno0_bits & USED_MASK;
    a_m[1] = in_data.a_geno1_bits & USED_MASK;
    a_m[2] = in_data.a_geno2_bits & USED_MASK;
    b_m[0] = in_data.b_geno0_bits & USED_MASK;
    b_m[1] = in_data.b_geno1_bits & USED_MASK;
    b_m[2] = in_data.b_geno2_bits & USED_MASK;
    entry.kind       = in_data.kind;
    entry.final_word = in_data.final_word;
    for (int i = 0; i < GENO_COUNT; i++) begin
      for (int j = 0; j < GENO_COUNT; j++) begin
        entry.pop[i * GENO_COUNT + j] = pop_count(a_m[i] & b_m[j]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/gpcc_queue.sv =====
`default_nettype none

module gpcc_queue
  import gpcc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t wr_entry,
  input  wire logic     pop,
  output q_stat_t       q_stat,
  output q_entry_t      rd_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t          mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  assign rd_entry     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.valid = (count_r != '0);

endmodule

`default_nettype wire

// ===== sv/gpcc_back.sv =====
`default_nettype none

module gpcc_back
  import gpcc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_stat_t  q_stat,
  input  wire q_entry_t rd_entry,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  function automatic logic [TALLY_W-1:0] sat_add(input logic [TALLY_W-1:0] t,
                                                 input logic [POP_W-1:0]   n);
    logic [TALLY_W:0] s;
    s = {1'b0, t} + (TALLY_W + 1)'(n);
    return s[TALLY_W] ? TALLY_MAX : s[TALLY_W-1:0];
  endfunction

  logic [TALLY_W-1:0] ctl_r [CELL_COUNT];
  logic [TALLY_W-1:0] cas_r [CELL_COUNT];
  logic [TALLY_W-1:0] ctl_nxt [CELL_COUNT];
  logic [TALLY_W-1:0] cas_nxt [CELL_COUNT];
  logic [TALLY_W-1:0] snap_ctl_r [CELL_COUNT];
  logic [TALLY_W-1:0] snap_cas_r [CELL_COUNT];
  logic               busy_r;
  logic [CELL_W-1:0]  cell_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  logic               load;
  logic               pop_final;

  // A final item waits until the previous run's last cell is loaded for output.
  assign pop       = q_stat.valid & (~rd_entry.final_word | ~busy_r);
  assign pop_final = pop & rd_entry.final_word;
  assign load      = busy_r & (~out_valid_r | out_ready);

  always_comb begin
    for (int c = 0; c < CELL_COUNT; c++) begin
      ctl_nxt[c] = ctl_r[c];
      cas_nxt[c] = cas_r[c];
      if (pop && rd_entry.kind == KIND_CASE) begin
        cas_nxt[c] = sat_add(cas_r[c], rd_entry.pop[c]);
      end else if (pop) begin
        ctl_nxt[c] = sat_add(ctl_r[c], rd_entry.pop[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CELL_COUNT; c++) begin
        ctl_r[c] <= '0;
        cas_r[c] <= '0;
      end
      busy_r      <= 1'b0;
      cell_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int c = 0; c < CELL_COUNT; c++) begin
        ctl_r[c] <= pop_final ? '0 : ctl_nxt[c];
        cas_r[c] <= pop_final ? '0 : cas_nxt[c];
      end
      if (pop_final) begin
        busy_r <= 1'b1;
        cell_r <= '0;
      end else if (load) begin
        busy_r <= (cell_r != LAST_CELL);
        cell_r <= cell_r + 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Snapshot drains by shifting toward entry zero, one cell per emitted item.
  always_ff @(posedge clk) begin
    if (pop_final) begin
      for (int c = 0; c < CELL_COUNT; c++) begin
        snap_ctl_r[c] <= ctl_nxt[c];
        snap_cas_r[c] <= cas_nxt[c];
      end
    end else if (load) begin
      for (int c = 0; c < CELL_COUNT - 1; c++) begin
        snap_ctl_r[c] <= snap_ctl_r[c + 1];
        snap_cas_r[c] <= snap_cas_r[c + 1];
      end
    end
    if (load) begin
      out_data_r.cell_index    <= cell_r;
      out_data_r.control_count <= snap_ctl_r[0];
      out_data_r.case_count    <= snap_cas_r[0];
      out_data_r.last_cell     <= (cell_r == LAST_CELL);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== verif/gpcc_checker.sv =====
`timescale 1ns / 100ps

module gpcc_checker
  import gpcc_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        errors,
  output int        pending,
  output int        cells_seen
);

  logic [TALLY_W-1:0] control_tally [CELL_COUNT];
  logic [TALLY_W-1:0] case_tally    [CELL_COUNT];
  out_item_t          cells_due [$];
  out_item_t          oldest_cell;

  initial begin
    errors     = 0;
    pending    = 0;
    cells_seen = 0;
    for (int c = 0; c < CELL_COUNT; c++) begin
      control_tally[c] = '0;
      case_tally[c]    = '0;
    end
  end

  function automatic logic [TALLY_W-1:0] tally_add(logic [TALLY_W-1:0] t, int unsigned n);
    logic [TALLY_W:0] s;
    s = {1'b0, t} + (TALLY_W + 1)'(n);
    return s[TALLY_W] ? TALLY_MAX : s[TALLY_W-1:0];
  endfunction

  // Adds one word's nine pair counts to the tallies; a final word also
  // queues the nine cells it closes and clears the tallies.
  task automatic tally_word(in_item_t w);
    logic [GENO_W-1:0] span;
    logic [GENO_W-1:0] a_bits [GENO_COUNT];
    logic [GENO_W-1:0] b_bits [GENO_COUNT];
    int unsigned       n;
    int                c;
    out_item_t         due_cell;
    span = '1;
    if (WORD_BITS < GENO_W) span = span >> (GENO_W - WORD_BITS);
    a_bits[0] = w.a_geno0_bits & span;
    a_bits[1] = w.a_geno1_bits & span;
    a_bits[2] = w.a_geno2_bits & span;
    b_bits[0] = w.b_geno0_bits & span;
    b_bits[1] = w.b_geno1_bits & span;
    b_bits[2] = w.b_geno2_bits & span;
    for (int i = 0; i < GENO_COUNT; i++) begin
      for (int j = 0; j < GENO_COUNT; j++) begin
        n = $countones(a_bits[i] & b_bits[j]);
        c = i * GENO_COUNT + j;
        if (w.kind == KIND_CASE) case_tally[c] = tally_add(case_tally[c], n);
        else control_tally[c] = tally_add(control_tally[c], n);
      end
    end
    if (w.final_word) begin
      for (c = 0; c < CELL_COUNT; c++) begin
        due_cell.cell_index    = CELL_W'(c);
        due_cell.control_count = control_tally[c];
        due_cell.case_count    = case_tally[c];
        due_cell.last_cell     = (due_cell.cell_index == LAST_CELL);
        cells_due.push_back(due_cell);
        control_tally[c] = '0;
        case_tally[c]    = '0;
      end
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tally_word(in_data);
      if (out_valid && out_ready) begin
        cells_seen++;
        if (cells_due.size() == 0) begin
          report("cell with none pending", out_data.cell_index, -1);
        end else begin
          oldest_cell = cells_due.pop_front();
          if (out_data.cell_index !== oldest_cell.cell_index)
            report("cell_index", out_data.cell_index, oldest_cell.cell_index);
          if (out_data.control_count !== oldest_cell.control_count)
            report("control_count", out_data.control_count, oldest_cell.control_count);
          if (out_data.case_count !== oldest_cell.case_count)
            report("case_count", out_data.case_count, oldest_cell.case_count);
          if (out_data.last_cell !== oldest_cell.last_cell)
            report("last_cell", out_data.last_cell, oldest_cell.last_cell);
        end
      end
      pending = cells_due.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import gpcc_pkg::*;

  // The watchdog limit covers the long receiver hold-off, the longest sender
  // gap and a full nine-cell drain several times over.
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 200;
  localparam int TAIL_CYCLES = 30;
  localparam int FULL_WORDS  = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int errors;
  int pending;
  int cells_seen;
  int idle_run = 0;
  bit steady   = 1'b0;
  bit held     = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  genotype_pair_contingency_counter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  gpcc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .errors     (errors),
    .pending    (pending),
    .cells_seen (cells_seen)
  );

  // Idle length for either side: mostly none, sometimes a few cycles and
  // now and then a long pause. Steady stretches run without any gaps.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_word(logic kind, logic [GENO_W-1:0] a0,
                                         logic [GENO_W-1:0] a1, logic [GENO_W-1:0] a2,
                                         logic [GENO_W-1:0] b0, logic [GENO_W-1:0] b1,
                                         logic [GENO_W-1:0] b2, logic fin);
    in_item_t w;
    w.kind         = kind;
    w.a_geno0_bits = a0;
    w.a_geno1_bits = a1;
    w.a_geno2_bits = a2;
    w.b_geno0_bits = b0;
    w.b_geno1_bits = b1;
    w.b_geno2_bits = b2;
    w.final_word   = fin;
    return w;
  endfunction

  function automatic logic [GENO_W-1:0] noise_mask();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return $urandom & $urandom & $urandom;
      4: return $urandom | $urandom;
      default: return GENO_W'(1) << $urandom_range(0, GENO_W - 1);
    endcase
  endfunction

  // Most words look like real genotype data: every sample carries exactly
  // one genotype per marker, or none when the call is missing. The rest are
  // arbitrary masks that may overlap.
  function automatic in_item_t random_word(logic fin);
    logic [GENO_W-1:0] a [GENO_COUNT];
    logic [GENO_W-1:0] b [GENO_COUNT];
    int unsigned       ga;
    int unsigned       gb;
    if ($urandom_range(0, 3) != 0) begin
      for (int g = 0; g < GENO_COUNT; g++) begin
        a[g] = '0;
        b[g] = '0;
      end
      for (int k = 0; k < GENO_W; k++) begin
        ga = $urandom_range(0, 3);
        gb = $urandom_range(0, 3);
        if (ga < GENO_COUNT) a[ga][k] = 1'b1;
        if (gb < GENO_COUNT) b[gb][k] = 1'b1;
      end
    end else begin
      for (int g = 0; g < GENO_COUNT; g++) begin
        a[g] = noise_mask();
        b[g] = noise_mask();
      end
    end
    return make_word(1'($urandom_range(0, 1)), a[0], a[1], a[2], b[0], b[1], b[2], fin);
  endfunction

  // Offers one item from a falling edge and returns at the falling edge
  // after it was taken, with valid still high.
  task automatic push_item(in_item_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stimulus and verdict.
  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    rst_n     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A final word right after reset: all nine cells come out as zero.
    push_item(make_word(KIND_CONTROL, '0, '0, '0, '0, '0, '0, 1'b1));
    // Full masks on both kinds give 32 in every cell of both counts, and the
    // final word's own counts are part of the output.
    push_item(make_word(KIND_CONTROL, '1, '1, '1, '1, '1, '1, 1'b0));
    push_item(make_word(KIND_CASE, '1, '1, '1, '1, '1, '1, 1'b1));
    // Masks of different weight, so that the cells get counts of 1, 4, 8 and 16.
    push_item(make_word(KIND_CONTROL, 32'h0000_0001, 32'h0000_00FF, 32'hFFFF_0000,
                        32'h8000_0001, 32'h0F0F_0F0F, 32'hFFFF_FFFF, 1'b0));
    push_item(make_word(KIND_CASE, 32'h0000_0001, 32'h0000_00FF, 32'hFFFF_0000,
                        32'h8000_0001, 32'h0F0F_0F0F, 32'hFFFF_FFFF, 1'b1));
    // Disjoint masks count nothing; equal checkerboards count half the word.
    push_item(make_word(KIND_CONTROL, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                        32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 1'b0));
    push_item(make_word(KIND_CASE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                        32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
    // Only the top bit, then only the bottom bit, of the word.
    push_item(make_word(KIND_CASE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    push_item(make_word(KIND_CONTROL, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                        32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b1));
    // Back-to-back final words while the previous cells are still going out.
    steady = 1'b1;
    repeat (4) push_item(random_word(1'b1));
    steady = 1'b0;

    // Random data sets of random length, in blocks with random idling, of which
    // the third and the seventh stream steadily.
    for (int blk = 0; blk < 9; blk++) begin
      steady = (blk % 4 == 2);
      repeat (50) push_item(random_word($urandom_range(0, 7) == 0));
    end
    steady = 1'b0;
    push_item(random_word(1'b1));

    // One data set of full words drives every cell of both tallies to a
    // large count before the final word clears them.
    for (int k = 0; k < FULL_WORDS; k++)
      push_item(make_word((k % 2 == 1) ? KIND_CASE : KIND_CONTROL,
                          '1, '1, '1, '1, '1, '1, k == FULL_WORDS - 1));
    push_item(random_word(1'b1));

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Result side: random ready patterns, plus one long hold-off once enough
  // cells have come, so that the queue fills and the input side stalls.
  initial begin
    int unsigned off;
    out_ready = 1'b0;
    do @(negedge clk); while (!rst_n);
    forever begin
      if (!held && cells_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk);
      off = pick_gap();
      if (off > 0) begin
        out_ready <= 1'b0;
        repeat (off) @(negedge clk);
      end
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

endmodule
